>>> hw/rtl/irn_pkg.sv
// Shared types and constants for the nearest-neighbour image rotator.
// Used by irn_map, image_rotate_nearest and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package irn_pkg;

  localparam int unsigned DEF_MAX_COLS       = 512;
  localparam int unsigned DEF_MAX_ROWS       = 512;
  localparam int unsigned DEF_TRIG_FRAC_BITS = 14;

  // Width of the cosine and sine registers.
  localparam int unsigned TRIG_W = 16;
  // Width of the frame size registers.
  localparam int unsigned SIZE_W = 10;

  localparam logic [SIZE_W-1:0]        FRAME_COLS_RST = 10'd512;
  localparam logic [SIZE_W-1:0]        FRAME_ROWS_RST = 10'd512;
  localparam logic signed [TRIG_W-1:0] COS_RST        = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SIN_RST        = 16'sd0;

  typedef enum logic [1:0] {
    REG_FRAME_COLS = 2'd0,
    REG_FRAME_ROWS = 2'd1,
    REG_COS_ANGLE  = 2'd2,
    REG_SIN_ANGLE  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    REQ_STORE = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

  // One request as it travels down the mapping pipeline.
  typedef struct packed {
    req_e       req;
    logic [8:0] col;
    logic [8:0] row;
    logic [7:0] pixel;
  } item_t;

endpackage

>>> hw/rtl/irn_map.sv
// Coordinate mapping pipeline: output position to source position.
// Four registered stages (offset, products, sums, truncation); uses irn_pkg.
`timescale 1ns / 1ps

module irn_map #(
  parameter int unsigned MAX_COLS       = irn_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS       = irn_pkg::DEF_MAX_ROWS,
  parameter int unsigned TRIG_FRAC_BITS = irn_pkg::DEF_TRIG_FRAC_BITS,
  localparam int unsigned CNT_W = $clog2((MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS) + 1),
  localparam int unsigned D_W   = CNT_W + 1,
  localparam int unsigned P_W   = D_W + irn_pkg::TRIG_W,
  localparam int unsigned H_W   = CNT_W + TRIG_FRAC_BITS + 1,
  localparam int unsigned S_W   = (P_W > H_W ? P_W : H_W) + 2,
  localparam int unsigned X_W   = S_W - TRIG_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  irn_pkg::item_t                     item_i,
  input  logic [CNT_W-1:0]                   cols_i,
  input  logic [CNT_W-1:0]                   rows_i,
  input  logic signed [irn_pkg::TRIG_W-1:0]  cos_i,
  input  logic signed [irn_pkg::TRIG_W-1:0]  sin_i,
  output logic                               valid_o,
  output irn_pkg::item_t                     item_o,
  output logic                               in_frame_o,
  output logic signed [X_W-1:0]              xs_o,
  output logic signed [X_W-1:0]              ys_o
);

  localparam int unsigned IN_W = (CNT_W > 9) ? CNT_W : 9;

  logic [CNT_W-1:0] hx, hy;
  assign hx = cols_i >> 1;
  assign hy = rows_i >> 1;

  // Stage 1: offsets from the centre and frame check of the request.
  logic                  v1_q;
  irn_pkg::item_t        it1_q;
  logic                  inf1_q;
  logic signed [D_W-1:0] dx1_q, dy1_q;
  logic signed [D_W-1:0] dx1_d, dy1_d;
  logic                  inf1_d;

  always_comb begin
    dx1_d  = $signed({1'b0, CNT_W'(item_i.col)}) - $signed({1'b0, hx});
    dy1_d  = $signed({1'b0, CNT_W'(item_i.row)}) - $signed({1'b0, hy});
    inf1_d = (IN_W'(item_i.col) < IN_W'(cols_i)) && (IN_W'(item_i.row) < IN_W'(rows_i));
  end

  // Stage 2: the four products.
  logic                  v2_q;
  irn_pkg::item_t        it2_q;
  logic                  inf2_q;
  logic signed [P_W-1:0] pxc_q, pys_q, pxs_q, pyc_q;

  // Stage 3: rotated positions, still with fraction bits.
  logic                  v3_q;
  irn_pkg::item_t        it3_q;
  logic                  inf3_q;
  logic signed [S_W-1:0] xa_q, ya_q;
  logic signed [S_W-1:0] xa_d, ya_d;
  logic signed [S_W-1:0] hx_sh, hy_sh;

  assign hx_sh = $signed(S_W'({hx, {TRIG_FRAC_BITS{1'b0}}}));
  assign hy_sh = $signed(S_W'({hy, {TRIG_FRAC_BITS{1'b0}}}));
  assign xa_d  = S_W'(pxc_q) - S_W'(pys_q) + hx_sh;
  assign ya_d  = S_W'(pxs_q) + S_W'(pyc_q) + hy_sh;

  // Stage 4: drop the fraction, rounding toward zero. Biasing a negative
  // value by one less than the scale turns the floor into a truncation.
  logic                  v4_q;
  irn_pkg::item_t        it4_q;
  logic                  inf4_q;
  logic signed [X_W-1:0] xs_q, ys_q;
  logic signed [S_W-1:0] xt, yt;
  logic        [S_W-1:0] bias;

  assign bias = S_W'({TRIG_FRAC_BITS{1'b1}});
  assign xt   = xa_q + (xa_q[S_W-1] ? $signed(bias) : $signed(S_W'(0)));
  assign yt   = ya_q + (ya_q[S_W-1] ? $signed(bias) : $signed(S_W'(0)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q  <= item_i;
      inf1_q <= inf1_d;
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;

      it2_q  <= it1_q;
      inf2_q <= inf1_q;
      pxc_q  <= dx1_q * cos_i;
      pys_q  <= dy1_q * sin_i;
      pxs_q  <= dx1_q * sin_i;
      pyc_q  <= dy1_q * cos_i;

      it3_q  <= it2_q;
      inf3_q <= inf2_q;
      xa_q   <= xa_d;
      ya_q   <= ya_d;

      it4_q  <= it3_q;
      inf4_q <= inf3_q;
      xs_q   <= xt[S_W-1:TRIG_FRAC_BITS];
      ys_q   <= yt[S_W-1:TRIG_FRAC_BITS];
    end
  end

  assign valid_o    = v4_q;
  assign item_o     = it4_q;
  assign in_frame_o = inf4_q;
  assign xs_o       = xs_q;
  assign ys_o       = ys_q;

endmodule

>>> hw/rtl/image_rotate_nearest.sv
// Top level of the nearest-neighbour image rotator: stream ports, registers,
// frame store and result register. Depends on irn_pkg and irn_map.
`timescale 1ns / 1ps

// Rotates an 8-bit grayscale frame about its centre. A beat with tuser low
// stores a source pixel at (col,row); a beat with tuser high asks for the
// rotated pixel at (col,row) and returns one beat holding the source pixel
// that maps there, or zero with tuser set when the request or its source
// lies outside the frame. Stores return nothing. The block takes one beat per
// clock while the result side keeps up; a read's answer passes the four
// mapping stages and the registered frame store read. The frame store is a
// single-port synchronous memory of MAX_COLS x MAX_ROWS bytes, each rounded
// up to a power of two, that stores and reads share in program order, so a
// read always sees every earlier store. It is not cleared at reset: read only
// pixels already stored. Size and angle registers may be written only while
// the block is idle; cosine and sine are signed, TRIG_FRAC_BITS fraction bits.
module image_rotate_nearest #(
  parameter int unsigned MAX_COLS       = irn_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS       = irn_pkg::DEF_MAX_ROWS,
  parameter int unsigned TRIG_FRAC_BITS = irn_pkg::DEF_TRIG_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Register write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // col[8:0], row[17:9], pixel[25:18], zero pad
  input  logic        s_axis_tuser,  // req_type
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_pixel
  output logic        m_axis_tuser   // outside
);

  localparam int unsigned CNT_W = $clog2((MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS) + 1);
  localparam int unsigned D_W   = CNT_W + 1;
  localparam int unsigned P_W   = D_W + irn_pkg::TRIG_W;
  localparam int unsigned H_W   = CNT_W + TRIG_FRAC_BITS + 1;
  localparam int unsigned S_W   = (P_W > H_W ? P_W : H_W) + 2;
  localparam int unsigned X_W   = S_W - TRIG_FRAC_BITS;
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned AW    = CW + RW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned SZ_W  = (CNT_W > irn_pkg::SIZE_W) ? CNT_W + 1 : irn_pkg::SIZE_W + 1;

  // Registers.
  logic [irn_pkg::SIZE_W-1:0]        frame_cols_q, frame_rows_q;
  logic signed [irn_pkg::TRIG_W-1:0] cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cols_q <= irn_pkg::FRAME_COLS_RST;
      frame_rows_q <= irn_pkg::FRAME_ROWS_RST;
      cos_q        <= irn_pkg::COS_RST;
      sin_q        <= irn_pkg::SIN_RST;
    end else if (cfg_we_i) begin
      unique case (irn_pkg::cfg_reg_e'(cfg_idx_i))
        irn_pkg::REG_FRAME_COLS: frame_cols_q <= cfg_data_i[irn_pkg::SIZE_W-1:0];
        irn_pkg::REG_FRAME_ROWS: frame_rows_q <= cfg_data_i[irn_pkg::SIZE_W-1:0];
        irn_pkg::REG_COS_ANGLE:  cos_q        <= $signed(cfg_data_i);
        irn_pkg::REG_SIN_ANGLE:  sin_q        <= $signed(cfg_data_i);
      endcase
    end
  end

  // Effective frame size, held within one and the maximum.
  logic [CNT_W-1:0] cols_eff, rows_eff;

  always_comb begin
    if (frame_cols_q == '0) begin
      cols_eff = CNT_W'(1);
    end else if (SZ_W'(frame_cols_q) > SZ_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(frame_cols_q);
    end
    if (frame_rows_q == '0) begin
      rows_eff = CNT_W'(1);
    end else if (SZ_W'(frame_rows_q) > SZ_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = CNT_W'(frame_rows_q);
    end
  end

  // The whole pipeline moves together; it halts only while a result waits.
  logic out_valid_q;
  logic en;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  irn_pkg::item_t in_item;
  assign in_item.req   = irn_pkg::req_e'(s_axis_tuser);
  assign in_item.col   = s_axis_tdata[8:0];
  assign in_item.row   = s_axis_tdata[17:9];
  assign in_item.pixel = s_axis_tdata[25:18];

  logic                  map_valid;
  irn_pkg::item_t        map_item;
  logic                  map_in_frame;
  logic signed [X_W-1:0] xs, ys;

  irn_map #(
    .MAX_COLS      (MAX_COLS),
    .MAX_ROWS      (MAX_ROWS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .item_i    (in_item),
    .cols_i    (cols_eff),
    .rows_i    (rows_eff),
    .cos_i     (cos_q),
    .sin_i     (sin_q),
    .valid_o   (map_valid),
    .item_o    (map_item),
    .in_frame_o(map_in_frame),
    .xs_o      (xs),
    .ys_o      (ys)
  );

  // Frame store access stage.
  logic          is_read, src_outside, do_write, do_read;
  logic [AW-1:0] wr_addr, rd_addr;

  always_comb begin
    is_read     = map_valid && (map_item.req == irn_pkg::REQ_READ);
    src_outside = !map_in_frame || xs[X_W-1] || ys[X_W-1]
                  || (xs >= $signed(X_W'(cols_eff)))
                  || (ys >= $signed(X_W'(rows_eff)));
    do_write    = en && map_valid && (map_item.req == irn_pkg::REQ_STORE) && map_in_frame;
    do_read     = en && is_read && !src_outside;
    wr_addr     = {RW'(map_item.row), CW'(map_item.col)};
    rd_addr     = {ys[RW-1:0], xs[CW-1:0]};
  end

  logic [7:0] frame_mem [DEPTH];
  logic [7:0] rd_q;
  logic       outside_q;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      frame_mem[wr_addr] <= map_item.pixel;
    end
    if (do_read) begin
      rd_q <= frame_mem[rd_addr];
    end
    if (en) begin
      outside_q <= src_outside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= is_read;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = outside_q ? 8'd0 : rd_q;
  assign m_axis_tuser  = outside_q;

endmodule

>>> test/tb_image_rotate_nearest.sv
// Self-checking bench for image_rotate_nearest: drives store and read beats,
// predicts each rotated pixel from its own copy of the frame and compares.
// Depends on irn_pkg and the image_rotate_nearest RTL.
`timescale 1ns / 1ps

module tb_image_rotate_nearest;
  import irn_pkg::*;

  localparam int unsigned COLS_MAX     = DEF_MAX_COLS;
  localparam int unsigned ROWS_MAX     = DEF_MAX_ROWS;
  localparam int unsigned FRAC_BITS    = DEF_TRIG_FRAC_BITS;
  localparam int          TOTAL_BEATS  = 1700;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          MAX_REPORTS  = 100;

  typedef struct packed {
    logic [7:0] pixel;
    logic       outside;
  } rotated_pixel_t;

  class rotation_scoreboard;
    bit [7:0]                 pixels [COLS_MAX*ROWS_MAX];
    bit                       written [COLS_MAX*ROWS_MAX];
    logic [SIZE_W-1:0]        cols_reg = FRAME_COLS_RST;
    logic [SIZE_W-1:0]        rows_reg = FRAME_ROWS_RST;
    logic signed [TRIG_W-1:0] cos_reg  = COS_RST;
    logic signed [TRIG_W-1:0] sin_reg  = SIN_RST;
    rotated_pixel_t           expected_pixels [$];
    int                       errors       = 0;
    int                       results_seen = 0;

    // Printing stops after a while so that a broken build cannot flood the log.
    task report(string msg);
      if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(cfg_reg_e idx, logic [15:0] data);
      case (idx)
        REG_FRAME_COLS: cols_reg = data[SIZE_W-1:0];
        REG_FRAME_ROWS: rows_reg = data[SIZE_W-1:0];
        REG_COS_ANGLE:  cos_reg  = data;
        REG_SIN_ANGLE:  sin_reg  = data;
      endcase
    endfunction

    function int frame_width();
      if (cols_reg == 0) return 1;
      return (cols_reg > COLS_MAX) ? COLS_MAX : int'(cols_reg);
    endfunction

    function int frame_height();
      if (rows_reg == 0) return 1;
      return (rows_reg > ROWS_MAX) ? ROWS_MAX : int'(rows_reg);
    endfunction

    // Shifts out the fraction, rounding toward zero on both signs.
    function longint drop_fraction(longint v);
      return (v < 0) ? -((-v) >>> FRAC_BITS) : (v >>> FRAC_BITS);
    endfunction

    // Maps an output position back to its source. Returns 1 when both the
    // request and the source lie inside the frame.
    function bit locate_source(int col, int row, output int src_col, output int src_row);
      int     cols = frame_width();
      int     rows = frame_height();
      longint hx   = cols / 2;
      longint hy   = rows / 2;
      longint dx   = col - hx;
      longint dy   = row - hy;
      longint c    = cos_reg;
      longint s    = sin_reg;
      src_col = -1;
      src_row = -1;
      if (col >= cols || row >= rows) return 1'b0;
      src_col = int'(drop_fraction(dx * c - dy * s + (hx <<< FRAC_BITS)));
      src_row = int'(drop_fraction(dx * s + dy * c + (hy <<< FRAC_BITS)));
      return src_col >= 0 && src_row >= 0 && src_col < cols && src_row < rows;
    endfunction

    function void note_request(item_t it);
      int             src_col;
      int             src_row;
      rotated_pixel_t res;
      if (it.req == REQ_STORE) begin
        if (it.col < frame_width() && it.row < frame_height()) begin
          pixels[it.row * COLS_MAX + it.col]  = it.pixel;
          written[it.row * COLS_MAX + it.col] = 1'b1;
        end
      end else begin
        res.pixel   = 8'd0;
        res.outside = 1'b1;
        if (locate_source(it.col, it.row, src_col, src_row)) begin
          res.pixel   = pixels[src_row * COLS_MAX + src_col];
          res.outside = 1'b0;
        end
        expected_pixels.push_back(res);
      end
    endfunction

    task check_pixel(logic [7:0] pixel, logic outside);
      rotated_pixel_t want;
      results_seen++;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want = expected_pixels.pop_front();
      if (pixel !== want.pixel)
        report($sformatf("result %0d pixel %h, expected %h", results_seen, pixel,
                         want.pixel));
      if (outside !== want.outside)
        report($sformatf("result %0d outside %b, expected %b", results_seen, outside,
                         want.outside));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;

  rotation_scoreboard rot_board;
  bit                 tx_idle = 1'b1;
  bit                 rx_idle = 1'b1;
  int                 beats_sent = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  image_rotate_nearest i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
  task automatic send_beat(input req_e req, input int col, input int row,
                           input logic [7:0] pixel);
    item_t it;
    int    gap;
    it.req   = req;
    it.col   = 9'(col);
    it.row   = 9'(row);
    it.pixel = pixel;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.req;
    s_axis_tdata  <= {6'd0, it.pixel, it.row, it.col};
    do @(posedge clk_i); while (!s_axis_tready);
    rot_board.note_request(it);
    beats_sent++;
  endtask

  // A read must never sample a pixel that was never stored, so the source
  // position is filled with a fresh value first where needed.
  task automatic request_rotated(input int col, input int row);
    int src_col;
    int src_row;
    if (rot_board.locate_source(col, row, src_col, src_row) &&
        !rot_board.written[src_row * COLS_MAX + src_col])
      send_beat(REQ_STORE, src_col, src_row, 8'($urandom));
    send_beat(REQ_READ, col, row, 8'($urandom));
  endtask

  // Stores give no result, so after the last expected result a drain wait lets them retire.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (rot_board.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    rot_board.set_reg(idx, data);
  endtask

  // The size registers keep the low ten bits; the upper bits carry noise.
  task automatic write_config(input logic [9:0] cols, input logic [9:0] rows,
                              input logic [15:0] cos_val, input logic [15:0] sin_val);
    put_reg(REG_FRAME_COLS, {6'($urandom), cols});
    put_reg(REG_FRAME_ROWS, {6'($urandom), rows});
    put_reg(REG_COS_ANGLE, cos_val);
    put_reg(REG_SIN_ANGLE, sin_val);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [9:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 10'd0;
      1:       return 10'($urandom_range(513, 1023));
      2:       return 10'd512;
      3, 4, 5: return 10'($urandom_range(1, 16));
      6, 7:    return 10'($urandom_range(17, 64));
      default: return 10'($urandom_range(65, 511));
    endcase
  endfunction

  // Returns {cos, sin}: common angles, in-range pairs, or any 16-bit values.
  function automatic logic [31:0] pick_trig();
    int c;
    int s;
    case ($urandom_range(0, 11))
      0:       return {16'sd16384, 16'sd0};
      1:       return {16'sd0, 16'sd16384};
      2:       return {-16'sd16384, 16'sd0};
      3:       return {16'sd0, -16'sd16384};
      4:       return {16'sd14189, 16'sd8192};
      5:       return {16'sd11585, 16'sd11585};
      6:       return {16'sd8192, -16'sd14189};
      7:       return {-16'sd11585, 16'sd11585};
      8, 9: begin
        c = int'($urandom_range(0, 32768)) - 16384;
        s = int'($urandom_range(0, 32768)) - 16384;
        return {16'(c), 16'(s)};
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] trig;
    int          phase_end;
    int          width;
    int          height;
    rot_board = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_FRAME_COLS;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_STORE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity mapping after reset: the four corners with all-ones, all-zeros and alternating pixel values.
    send_beat(REQ_STORE, 0, 0, 8'hFF);
    send_beat(REQ_STORE, COLS_MAX - 1, ROWS_MAX - 1, 8'h00);
    send_beat(REQ_STORE, COLS_MAX - 1, 0, 8'hAA);
    send_beat(REQ_STORE, 0, ROWS_MAX - 1, 8'h55);
    request_rotated(0, 0);
    request_rotated(COLS_MAX - 1, ROWS_MAX - 1);
    request_rotated(COLS_MAX - 1, 0);
    request_rotated(0, ROWS_MAX - 1);
    settle();

    // Oversized column count and zero row count both saturate; half turn.
    write_config(10'd1023, 10'd0, -16'sd16384, 16'sd0);
    send_beat(REQ_STORE, 5, 1, 8'h3C);
    request_rotated(5, 1);
    request_rotated(5, 0);
    settle();

    // Most negative trig values on a two-by-two frame.
    write_config(10'd2, 10'd2, 16'h8000, 16'h8000);
    request_rotated(0, 0);
    request_rotated(1, 1);
    settle();

    // Quarter turn on the full frame.
    write_config(10'd512, 10'd512, 16'sd0, 16'sd16384);
    request_rotated(COLS_MAX - 1, 0);
    request_rotated(0, ROWS_MAX - 1);
    request_rotated(COLS_MAX / 2, ROWS_MAX / 2);

    while (beats_sent < TOTAL_BEATS) begin
      settle();
      trig = pick_trig();
      write_config(pick_size(), pick_size(), trig[31:16], trig[15:0]);
      tx_idle   = ($urandom_range(0, 3) != 0);
      rx_idle   = ($urandom_range(0, 3) != 0);
      phase_end = beats_sent + $urandom_range(60, 200);
      width     = rot_board.frame_width();
      height    = rot_board.frame_height();
      while (beats_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0:
            send_beat(REQ_STORE, $urandom_range(0, COLS_MAX - 1),
                      $urandom_range(0, ROWS_MAX - 1), 8'($urandom));
          1, 2, 3:
            send_beat(REQ_STORE, $urandom_range(0, width - 1),
                      $urandom_range(0, height - 1), 8'($urandom));
          4:
            request_rotated($urandom_range(0, COLS_MAX - 1), $urandom_range(0, ROWS_MAX - 1));
          default:
            request_rotated($urandom_range(0, width - 1), $urandom_range(0, height - 1));
        endcase
      end
    end
    settle();

    if (rot_board.errors == 0) begin
      $display("tb_image_rotate_nearest: clean");
    end else begin
      $display("tb_image_rotate_nearest: errors");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      rot_board.check_pixel(m_axis_tdata, m_axis_tuser);
    end
  end

  // Ends the run when neither side has moved a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_image_rotate_nearest: errors");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/irn_pkg.sv
hw/rtl/irn_map.sv
hw/rtl/image_rotate_nearest.sv
test/tb_image_rotate_nearest.sv
